### design/stia_pkg.sv
// Shared types, codes and defaults for the slot table id allocator.
package stia_pkg;

   localparam int SLOTS_DEFAULT      = 256;
   localparam int VALUE_BITS_DEFAULT = 32;

   localparam logic [2:0] KIND_INSERT_FIRST = 3'd0;
   localparam logic [2:0] KIND_INSERT_AT    = 3'd1;
   localparam logic [2:0] KIND_REMOVE       = 3'd2;
   localparam logic [2:0] KIND_RELEASE      = 3'd3;
   localparam logic [2:0] KIND_LOOKUP       = 3'd4;
   localparam logic [2:0] KIND_CLEAR        = 3'd5;
   localparam logic [2:0] KIND_GROW         = 3'd6;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_INVALID   = 3'd1;
   localparam logic [2:0] ST_OCCUPIED  = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NO_CHANGE = 3'd4;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  slot_id;
      logic [31:0] value;
      logic [8:0]  grow_size;
   } stia_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  result_id;
      logic [31:0] value_out;
      logic [8:0]  live_count;
      logic [8:0]  used_size;
      logic [8:0]  first_free;
   } stia_rsp_type;

   typedef enum logic [2:0] {
      S_WIPE,
      S_IDLE,
      S_READ,
      S_EXEC,
      S_PROBE,
      S_CHECK,
      S_CLEAR,
      S_DONE
   } stia_state_type;

   typedef struct packed {
      logic load_req;
      logic mem_read;
      logic exec;
      logic probe;
      logic advance;
      logic wipe;
      logic load_rsp;
   } stia_cmd_type;

   typedef struct packed {
      logic is_clear;
      logic need_search;
      logic scan_more;
      logic rd_nonzero;
      logic wipe_last;
      logic rsp_free;
   } stia_stat_type;

endpackage

### design/stia_datapath.sv
// Datapath: slot memory, table counters, operation execute logic and result register.
module stia_datapath #(
   parameter int SLOTS      = 256,
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  stia_pkg::stia_cmd_type  cmd,
   output stia_pkg::stia_stat_type stat,
   input  stia_pkg::stia_req_type  req_data,
   output stia_pkg::stia_rsp_type  rsp_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall
);
   import stia_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   logic [VALUE_BITS-1:0] store_mem [SLOTS];

   stia_req_type          req_ff;
   logic [VALUE_BITS-1:0] rd_data_ff;
   logic [CW-1:0]         size_ff;
   logic [CW-1:0]         fv_ff;
   logic [CW-1:0]         count_ff;
   logic [2:0]            status_ff;
   logic [7:0]            rid_ff;
   logic [31:0]           vout_ff;
   logic [IW-1:0]         wipe_ptr_ff;
   stia_rsp_type          rsp_ff;
   logic                  rsp_valid_ff;

   logic [CW-1:0]         size_in;
   logic [CW-1:0]         fv_in;
   logic [CW-1:0]         count_in;
   logic [2:0]            status_in;
   logic [7:0]            rid_in;
   logic [31:0]           vout_in;
   logic                  wr_en;
   logic [VALUE_BITS-1:0] wr_data;
   logic                  need_search;
   logic [31:0]           id_w;
   logic [31:0]           fv_w;
   logic [31:0]           size_w;
   logic [31:0]           put_w;
   logic [31:0]           grow_w;
   logic [VALUE_BITS-1:0] val;
   logic [IW-1:0]         put_idx;
   logic                  wipe_last;
   logic                  rsp_free;

   always_comb begin
      id_w    = 32'(req_ff.slot_id);
      fv_w    = 32'(fv_ff);
      size_w  = 32'(size_ff);
      put_w   = (req_ff.kind == KIND_INSERT_FIRST) ? fv_w : id_w;
      put_idx = put_w[IW-1:0];
      grow_w  = (32'(req_ff.grow_size) > 32'(SLOTS)) ? 32'(SLOTS) : 32'(req_ff.grow_size);
      val     = VALUE_BITS'(req_ff.value);

      status_in   = ST_NO_CHANGE;
      rid_in      = req_ff.slot_id;
      vout_in     = '0;
      size_in     = size_ff;
      fv_in       = fv_ff;
      count_in    = count_ff;
      wr_en       = 1'b0;
      wr_data     = '0;
      need_search = 1'b0;

      unique case (req_ff.kind) inside
         KIND_INSERT_FIRST, KIND_INSERT_AT: begin
            if (req_ff.kind == KIND_INSERT_FIRST) begin
               rid_in = 8'(fv_ff);
            end
            if (put_w >= 32'(SLOTS)) begin
               status_in = (req_ff.kind == KIND_INSERT_FIRST) ? ST_FULL : ST_INVALID;
            end else begin
               if (put_w >= size_w) begin
                  size_in = CW'(put_w + 32'd1);
               end
               if (rd_data_ff != '0) begin
                  status_in = ST_OCCUPIED;
               end else if (val == '0) begin
                  status_in = ST_NO_CHANGE;
               end else begin
                  status_in   = ST_OK;
                  wr_en       = 1'b1;
                  wr_data     = val;
                  count_in    = count_ff + CW'(1);
                  need_search = 1'b1;
               end
            end
         end
         KIND_REMOVE, KIND_RELEASE, KIND_LOOKUP: begin
            if (id_w < size_w && rd_data_ff != '0) begin
               status_in = ST_OK;
               if (req_ff.kind != KIND_REMOVE) begin
                  vout_in = 32'(rd_data_ff);
               end
               if (req_ff.kind != KIND_LOOKUP) begin
                  wr_en    = 1'b1;
                  count_in = count_ff - CW'(1);
                  if (fv_w > id_w) begin
                     fv_in = CW'(id_w);
                  end
               end
            end else begin
               status_in = ST_INVALID;
            end
         end
         KIND_CLEAR: begin
            status_in = ST_OK;
            size_in   = '0;
            fv_in     = '0;
            count_in  = '0;
         end
         KIND_GROW: begin
            if (grow_w > size_w) begin
               size_in   = CW'(grow_w);
               status_in = ST_OK;
            end
         end
         default: begin
         end
      endcase
   end

   assign wipe_last = (wipe_ptr_ff == IW'(SLOTS - 1));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      stat.is_clear    = (req_ff.kind == KIND_CLEAR);
      stat.need_search = need_search;
      stat.scan_more   = (fv_w < size_w) && (fv_w < 32'(SLOTS));
      stat.rd_nonzero  = (rd_data_ff != '0);
      stat.wipe_last   = wipe_last;
      stat.rsp_free    = rsp_free;
   end

   always_ff @(posedge clock) begin
      if (cmd.wipe) begin
         store_mem[wipe_ptr_ff] <= '0;
      end else if (cmd.exec && wr_en) begin
         store_mem[put_idx] <= wr_data;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= store_mem[put_idx];
      end else if (cmd.probe) begin
         rd_data_ff <= store_mem[fv_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         rid_ff    <= rid_in;
         vout_ff   <= vout_in;
      end
      if (cmd.load_rsp) begin
         rsp_ff.status     <= status_ff;
         rsp_ff.result_id  <= rid_ff;
         rsp_ff.value_out  <= vout_ff;
         rsp_ff.live_count <= 9'(count_ff);
         rsp_ff.used_size  <= 9'(size_ff);
         rsp_ff.first_free <= 9'(fv_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= '0;
         fv_ff        <= '0;
         count_ff     <= '0;
         wipe_ptr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            size_ff  <= size_in;
            fv_ff    <= fv_in;
            count_ff <= count_in;
         end else if (cmd.advance) begin
            fv_ff <= fv_ff + CW'(1);
         end
         if (cmd.wipe) begin
            wipe_ptr_ff <= wipe_last ? '0 : wipe_ptr_ff + IW'(1);
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/stia_ctrl.sv
// Controller state machine: sequences read, execute, first-vacant scan and clear sweep.
module stia_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  stia_pkg::stia_stat_type stat,
   output stia_pkg::stia_cmd_type  cmd
);
   import stia_pkg::*;

   stia_state_type state_ff;
   stia_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_WIPE: begin
            if (stat.wipe_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (stat.is_clear) begin
               state_in = S_CLEAR;
            end else if (stat.need_search) begin
               state_in = S_PROBE;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PROBE: begin
            state_in = stat.scan_more ? S_CHECK : S_DONE;
         end
         S_CHECK: begin
            state_in = stat.rd_nonzero ? S_PROBE : S_DONE;
         end
         S_CLEAR: begin
            if (stat.wipe_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_WIPE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_WIPE: begin
            cmd.wipe = 1'b1;
         end
         S_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         S_READ: begin
            cmd.mem_read = 1'b1;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
         end
         S_PROBE: begin
            cmd.probe = stat.scan_more;
         end
         S_CHECK: begin
            cmd.advance = stat.rd_nonzero;
         end
         S_CLEAR: begin
            cmd.wipe = 1'b1;
         end
         S_DONE: begin
            cmd.load_rsp = stat.rsp_free;
         end
         default: begin
         end
      endcase
   end

endmodule

### design/slot_table_id_allocator.sv
// Top level of the slot table id allocator: controller, datapath and checks.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------
//   req     | in        | req_valid, req_stall | req_data (stia_req_type)
//   rsp     | out       | rsp_valid, rsp_stall | rsp_data (stia_rsp_type)
//
// An item runs through accept, memory read, execute and result load when no scan runs.
// An insert that stores a value adds a probe and a check state for each slot probed by the
// first-vacant scan, plus a probe state when the scan stops at the used size; each probe reads the single memory port.
// A clear item runs a sweep that writes one slot per cycle.
// After reset the same sweep runs with req_stall high.
// One item is in work at a time; a finished result waits in the output register while the
// next item is accepted, and a stalled result only holds the item after it at its end.
module slot_table_id_allocator #(
   parameter int SLOTS      = stia_pkg::SLOTS_DEFAULT,
   parameter int VALUE_BITS = stia_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  stia_pkg::stia_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output stia_pkg::stia_rsp_type rsp_data
);
   import stia_pkg::*;

   stia_cmd_type  cmd;
   stia_stat_type stat;

   stia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   stia_datapath #(
      .SLOTS      (SLOTS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

   a_one_item_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while another is in work");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> stat.rsp_free)
      else $error("result register loaded while a stalled item waits");

   a_result_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.load_rsp))
      else $error("result valid without a result load");

   a_sweep_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.wipe |-> (!cmd.exec && !cmd.mem_read && !cmd.probe && !cmd.load_rsp))
      else $error("slot memory sweep overlaps other work");

endmodule

### dv/slot_table_id_allocator_checker.sv
`timescale 1ns / 1ps
// Checker for the slot table id allocator: predicts every result and compares it.
module slot_table_id_allocator_checker
   import stia_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  stia_req_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  stia_rsp_type rsp_data,
   output int           fail_count,
   output int           pending,
   output int           checked
);

   logic [31:0]  slot_val [SLOTS];
   int unsigned  used_sz;
   int unsigned  vacant;
   int unsigned  live;
   stia_rsp_type expected_rsp_q [$];

   function automatic void wipe_table();
      for (int i = 0; i < SLOTS; i++) begin
         slot_val[i] = '0;
      end
      used_sz = 0;
      vacant  = 0;
      live    = 0;
   endfunction

   function automatic logic [2:0] place_value(int unsigned id, logic [31:0] v);
      if (id >= SLOTS) begin
         return ST_INVALID;
      end
      if (id >= used_sz) begin
         used_sz = id + 1;
      end
      if (slot_val[id] != 0) begin
         return ST_OCCUPIED;
      end
      if (v == 0) begin
         return ST_NO_CHANGE;
      end
      slot_val[id] = v;
      live++;
      while (vacant < used_sz && vacant < SLOTS && slot_val[vacant] != 0) begin
         vacant++;
      end
      return ST_OK;
   endfunction

   function automatic stia_rsp_type predict_slot_op(stia_req_type item);
      stia_rsp_type r;
      int unsigned  id;
      int unsigned  size;
      id          = 32'(item.slot_id);
      size        = 32'(item.grow_size);
      r           = '0;
      r.status    = ST_NO_CHANGE;
      r.result_id = item.slot_id;
      case (item.kind) inside
         KIND_INSERT_FIRST: begin
            r.result_id = 8'(vacant);
            if (vacant >= SLOTS) begin
               r.status = ST_FULL;
            end else begin
               r.status = place_value(vacant, item.value);
            end
         end
         KIND_INSERT_AT: begin
            r.status = place_value(id, item.value);
         end
         KIND_REMOVE, KIND_RELEASE, KIND_LOOKUP: begin
            if (!(id < used_sz && id < SLOTS && slot_val[id] != 0)) begin
               r.status = ST_INVALID;
            end else begin
               r.status = ST_OK;
               if (item.kind != KIND_REMOVE) begin
                  r.value_out = slot_val[id];
               end
               if (item.kind != KIND_LOOKUP) begin
                  slot_val[id] = '0;
                  live--;
                  if (vacant > id) begin
                     vacant = id;
                  end
               end
            end
         end
         KIND_CLEAR: begin
            wipe_table();
            r.status = ST_OK;
         end
         KIND_GROW: begin
            if (size > SLOTS) begin
               size = SLOTS;
            end
            if (size > used_sz) begin
               used_sz  = size;
               r.status = ST_OK;
            end
         end
         default: begin
         end
      endcase
      r.live_count = 9'(live);
      r.used_size  = 9'(used_sz);
      r.first_free = 9'(vacant);
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s at result %0d: got %0d, expected %0d",
               field, checked, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      stia_rsp_type want;
      if (reset) begin
         wipe_table();
         expected_rsp_q.delete();
         fail_count = 0;
         checked <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("result with nothing expected",
                               32'(rsp_data.result_id), 32'd0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
               if (rsp_data.result_id !== want.result_id)
                  report_mismatch("result_id", 32'(rsp_data.result_id),
                                  32'(want.result_id));
               if (rsp_data.value_out !== want.value_out)
                  report_mismatch("value_out", rsp_data.value_out, want.value_out);
               if (rsp_data.live_count !== want.live_count)
                  report_mismatch("live_count", 32'(rsp_data.live_count),
                                  32'(want.live_count));
               if (rsp_data.used_size !== want.used_size)
                  report_mismatch("used_size", 32'(rsp_data.used_size),
                                  32'(want.used_size));
               if (rsp_data.first_free !== want.first_free)
                  report_mismatch("first_free", 32'(rsp_data.first_free),
                                  32'(want.first_free));
               checked <= checked + 1;
            end
         end
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(predict_slot_op(req_data));
         end
      end
      pending <= expected_rsp_q.size();
   end

endmodule

### dv/slot_table_id_allocator_test.sv
`timescale 1ns / 1ps
// Testbench top for the slot table id allocator: stimulus, idling and the verdict.
module slot_table_id_allocator_test;
   import stia_pkg::*;

   localparam logic [2:0] KIND_UNUSED = 3'd7;
   localparam int RANDOM_ITEMS = 850;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 4 * SLOTS_DEFAULT + 100;
   localparam int CYCLE_LIMIT  = 3_000_000;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   stia_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   stia_rsp_type rsp_data;

   int fail_count;
   int pending;
   int checked;
   int items_sent;
   int directed_items;
   int holds_done;
   int cycle_count = 0;
   bit no_idle;
   bit hold_off_req;
   bit fill_done;

   slot_table_id_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   slot_table_id_allocator_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending);
         $display("slot_table_id_allocator verification failed");
         $finish;
      end
   end

   function automatic stia_req_type make_op(logic [2:0] kind, logic [7:0] id,
                                            logic [31:0] value, logic [8:0] size);
      stia_req_type item;
      item.kind      = kind;
      item.slot_id   = id;
      item.value     = value;
      item.grow_size = size;
      return item;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [7:0] pick_id();
      if ($urandom_range(0, 7) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return 8'($urandom_range(0, 15));
   endfunction

   function automatic stia_req_type mixed_op();
      int         pick;
      logic [8:0] size;
      pick = $urandom_range(0, 99);
      size = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                         : 9'($urandom_range(0, 40));
      if (pick < 30)
         return make_op(KIND_INSERT_FIRST, 8'($urandom), pick_value(), 9'($urandom));
      if (pick < 42)
         return make_op(KIND_INSERT_AT, pick_id(), pick_value(), 9'($urandom));
      if (pick < 54)
         return make_op(KIND_REMOVE, pick_id(), $urandom(), 9'($urandom));
      if (pick < 66)
         return make_op(KIND_RELEASE, pick_id(), $urandom(), 9'($urandom));
      if (pick < 80)
         return make_op(KIND_LOOKUP, pick_id(), $urandom(), 9'($urandom));
      if (pick < 88)
         return make_op(KIND_GROW, 8'($urandom), $urandom(), size);
      if (pick < 91)
         return make_op(KIND_CLEAR, 8'($urandom), $urandom(), 9'($urandom));
      if (pick < 93)
         return make_op(KIND_UNUSED, 8'($urandom), $urandom(), 9'($urandom));
      return make_op(KIND_INSERT_FIRST, 8'($urandom), pick_value(), 9'($urandom));
   endfunction

   task automatic offer_item(input stia_req_type item);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   // result side: random stall per item, plus long hold-offs on request
   initial begin
      int stall_cycles;
      rsp_stall = 1'b0;
      forever begin
         stall_cycles = no_idle ? 0 : $urandom_range(0, 3);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_cycles += HOLD_CYCLES;
            holds_done++;
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int episode_len;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      offer_item(make_op(KIND_LOOKUP, 8'd0, 32'd0, 9'd0));
      offer_item(make_op(KIND_REMOVE, 8'd255, 32'd0, 9'd0));
      offer_item(make_op(KIND_INSERT_FIRST, 8'd0, 32'hFFFF_FFFF, 9'd0));
      offer_item(make_op(KIND_INSERT_FIRST, 8'd255, 32'h0000_0001, 9'h1FF));
      offer_item(make_op(KIND_INSERT_FIRST, 8'd0, 32'h0000_0000, 9'd0));
      offer_item(make_op(KIND_INSERT_AT, 8'd10, 32'hA5A5_5A5A, 9'd0));
      offer_item(make_op(KIND_INSERT_AT, 8'd10, 32'h0000_0007, 9'd0));
      offer_item(make_op(KIND_INSERT_AT, 8'd255, 32'h8000_0001, 9'd0));
      offer_item(make_op(KIND_INSERT_AT, 8'd200, 32'h0000_0000, 9'd0));
      offer_item(make_op(KIND_LOOKUP, 8'd10, 32'hFFFF_FFFF, 9'd0));
      offer_item(make_op(KIND_RELEASE, 8'd1, 32'd0, 9'd0));
      offer_item(make_op(KIND_REMOVE, 8'd0, 32'd0, 9'd0));
      offer_item(make_op(KIND_LOOKUP, 8'd0, 32'd0, 9'd0));
      offer_item(make_op(KIND_RELEASE, 8'd255, 32'd0, 9'd0));
      offer_item(make_op(KIND_GROW, 8'd0, 32'd0, 9'd100));
      offer_item(make_op(KIND_CLEAR, 8'hFF, 32'hFFFF_FFFF, 9'h1FF));
      offer_item(make_op(KIND_GROW, 8'd0, 32'd0, 9'h1FF));
      offer_item(make_op(KIND_GROW, 8'd0, 32'd0, 9'd0));
      offer_item(make_op(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 9'h1FF));
      offer_item(make_op(KIND_GROW, 8'd0, 32'd0, 9'd300));
      offer_item(make_op(KIND_CLEAR, 8'd0, 32'd0, 9'd0));
      offer_item(make_op(KIND_GROW, 8'd0, 32'd0, 9'd4));
      offer_item(make_op(KIND_LOOKUP, 8'd3, 32'd0, 9'd0));
      offer_item(make_op(KIND_INSERT_AT, 8'd0, 32'h0000_0005, 9'd0));
      offer_item(make_op(KIND_REMOVE, 8'd128, 32'd0, 9'd0));
      directed_items = items_sent;

      hold_off_req = 1'b1;
      while (items_sent < directed_items + RANDOM_ITEMS) begin
         no_idle     = ($urandom_range(0, 3) == 0);
         episode_len = $urandom_range(20, 60);
         if (!fill_done && items_sent > directed_items + 250) begin
            fill_done    = 1'b1;
            hold_off_req = 1'b1;
            offer_item(make_op(KIND_CLEAR, 8'($urandom), $urandom(), 9'($urandom)));
            repeat (SLOTS_DEFAULT + 3) begin
               offer_item(make_op(KIND_INSERT_FIRST, 8'($urandom), pick_value() | 32'd1,
                                  9'($urandom)));
            end
            repeat (30) begin
               case ($urandom_range(0, 3))
                  0: offer_item(make_op(KIND_REMOVE, 8'($urandom), $urandom(), 9'($urandom)));
                  1: offer_item(make_op(KIND_RELEASE, 8'($urandom), $urandom(), 9'($urandom)));
                  2: offer_item(make_op(KIND_LOOKUP, 8'($urandom), $urandom(), 9'($urandom)));
                  default: offer_item(make_op(KIND_INSERT_FIRST, 8'($urandom), pick_value(),
                                              9'($urandom)));
               endcase
            end
            repeat (40) begin
               offer_item(make_op(KIND_INSERT_FIRST, 8'($urandom), pick_value() | 32'd1,
                                  9'($urandom)));
            end
         end else begin
            if ($urandom_range(0, 9) == 0) begin
               hold_off_req = 1'b1;
            end
            repeat (episode_len) offer_item(mixed_op());
         end
      end

      no_idle = 1'b0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d items (%0d directed), %0d results compared in %0d cycles",
               items_sent, directed_items, checked, cycle_count);
      $display("summary: all kinds, a full table refused and refilled, %0d long output holds",
               holds_done);
      if (fail_count == 0 && pending == 0) begin
         $display("slot_table_id_allocator verification clean");
      end else begin
         $display("slot_table_id_allocator verification failed");
      end
      $finish;
   end

endmodule

### files.f
design/stia_pkg.sv
design/stia_datapath.sv
design/stia_ctrl.sv
design/slot_table_id_allocator.sv
dv/slot_table_id_allocator_checker.sv
dv/slot_table_id_allocator_test.sv
